[hw/rtl/dea_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended stack allocator package
// Field widths, request codes, register indexes and reset values shared by
// the allocator RTL.
// ----------------------------------------------------------------------------
package dea_pkg;

    // Default width of a stack offset; a used count is one bit wider.
    localparam int DEF_OFFSET_BITS = 20;

    // Fixed field widths of the request and result items.
    localparam int REQ_W    = 2;
    localparam int SIZE_W   = 21;
    localparam int ALIGN_W  = 4;
    localparam int MARKER_W = 21;
    localparam int ADDR_W   = 32;
    localparam int CAP_W    = 21;

    // Alignment mask width: enough for any 4-bit exponent.
    localparam int AMASK_W  = 16;

    // Stream packing widths (whole bytes).
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 1'd1;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 21'd1048576;

    // Request kinds.
    localparam logic [REQ_W-1:0] REQ_ALLOC_FRONT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ALLOC_BACK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESET_FRONT = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RESET_BACK  = 2'd3;

endpackage

[hw/rtl/double_ended_stack_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended stack allocator
// Two stacks share one region: the front stack grows up from base_address,
// the back stack grows down from base_address + capacity. Allocations are
// aligned to a power of two and refused on overlap or a busy marker slot;
// reset requests roll a stack back to a marker.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake          Contents
// s_*      in   tvalid / tready    one request item (tuser = kind)
// m_*      out  tvalid / tready    one result item per request
// cfg_*    in   cfg_we             base_address / capacity writes
//
// Each request is held in the input register and then moves to the
// result register, from which its result is offered; one request is taken
// per cycle while the result side does not stall. The only loop is the
// used-count registers, which are read and updated in the compute step
// between the two registers.
// A stalled result register holds its item; the input register then holds
// one more item and s_tready drops. Reset (synchronous, active low) empties
// both registers, clears both used counts and restores the register defaults.
//
module double_ended_stack_allocator #(
    parameter int OFFSET_BITS = dea_pkg::DEF_OFFSET_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [dea_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dea_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    // Request channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata fields from bit 0: size[20:0], align_log2[24:21], marker[45:25],
    // marker_slot_free[46], zero[47]
    input  logic [dea_pkg::S_TDATA_W-1:0]     s_tdata,
    // tuser fields from bit 0: req_type[1:0]
    input  logic [dea_pkg::REQ_W-1:0]         s_tuser,

    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata fields from bit 0: ok[0], address[32:1], marker_out[53:33],
    // zero[55:54]
    output logic [dea_pkg::M_TDATA_W-1:0]     m_tdata
);
    import dea_pkg::*;

    localparam int USED_W = OFFSET_BITS + 1;
    localparam int SUM_W  = ((USED_W > SIZE_W) ? USED_W : SIZE_W) + 3;

    // Configuration registers.
    logic [ADDR_W-1:0]   base_reg;
    logic [CAP_W-1:0]    capacity_reg;

    // Stack state.
    logic [USED_W-1:0]   front_used_reg, front_used_next;
    logic [USED_W-1:0]   back_used_reg, back_used_next;

    // Input register.
    logic                in_valid_reg;
    logic [REQ_W-1:0]    req_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [ALIGN_W-1:0]  align_reg;
    logic [MARKER_W-1:0] marker_reg;
    logic                slot_free_reg;

    // Result register.
    logic                out_valid_reg;
    logic                ok_reg, ok_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [MARKER_W-1:0] mk_reg, mk_next;

    logic                advance;
    logic                load_in;

    // Datapath intermediates.
    logic [AMASK_W-1:0]  amask;
    logic [ADDR_W-1:0]   f_cur;
    logic [AMASK_W-1:0]  f_pad;
    logic [SUM_W-1:0]    f_grow;
    logic [SUM_W-1:0]    f_total;
    logic                f_fit;
    logic [SUM_W-1:0]    b_grow0;
    logic [ADDR_W-1:0]   b_below;
    logic [AMASK_W-1:0]  b_pad;
    logic [SUM_W-1:0]    b_grow;
    logic [SUM_W-1:0]    b_total;
    logic                b_fit;
    logic [SUM_W-1:0]    cap_ext;

    // Handshake: the compute step fires when the input register holds an
    // item and the result register is empty or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign load_in  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, mk_reg, addr_reg, ok_reg};

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg     <= '0;
            capacity_reg <= CAPACITY_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_BASE_ADDRESS: base_reg     <= cfg_wdata;
                CFG_CAPACITY:     capacity_reg <= cfg_wdata[CAP_W-1:0];
                default:          ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (load_in) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_in) begin
            req_reg       <= s_tuser;
            size_reg      <= s_tdata[20:0];
            align_reg     <= s_tdata[24:21];
            marker_reg    <= s_tdata[45:25];
            slot_free_reg <= s_tdata[46];
        end
    end

    // Front allocation: pad the current top up to the alignment.
    assign amask   = ~({AMASK_W{1'b1}} << align_reg);
    assign cap_ext = SUM_W'(capacity_reg);
    assign f_cur   = base_reg + ADDR_W'(front_used_reg);
    assign f_pad   = (~f_cur[AMASK_W-1:0] + AMASK_W'(1)) & amask;
    assign f_grow  = SUM_W'(front_used_reg) + SUM_W'(size_reg) + SUM_W'(f_pad);
    assign f_total = f_grow + SUM_W'(back_used_reg);
    assign f_fit   = f_total <= cap_ext;

    // Back allocation: place the block below the back stack, pad downward.
    assign b_grow0 = SUM_W'(back_used_reg) + SUM_W'(size_reg);
    assign b_below = base_reg + ADDR_W'(capacity_reg) - ADDR_W'(b_grow0);
    assign b_pad   = b_below[AMASK_W-1:0] & amask;
    assign b_grow  = b_grow0 + SUM_W'(b_pad);
    assign b_total = b_grow + SUM_W'(front_used_reg);
    assign b_fit   = b_total <= cap_ext;

    // Result and state update for the item in the input register.
    always_comb begin
        front_used_next = front_used_reg;
        back_used_next  = back_used_reg;
        ok_next         = 1'b1;
        addr_next       = '0;
        mk_next         = '0;
        case (req_reg)
            REQ_ALLOC_FRONT: begin
                if (f_fit && slot_free_reg) begin
                    front_used_next = USED_W'(f_grow);
                    addr_next       = f_cur + ADDR_W'(f_pad);
                    mk_next         = MARKER_W'(front_used_reg);
                end else begin
                    ok_next = 1'b0;
                end
            end
            REQ_ALLOC_BACK: begin
                if (b_fit && slot_free_reg) begin
                    back_used_next = USED_W'(b_grow);
                    addr_next      = b_below - ADDR_W'(b_pad);
                    mk_next        = MARKER_W'(back_used_reg);
                end else begin
                    ok_next = 1'b0;
                end
            end
            REQ_RESET_FRONT: begin
                if (SUM_W'(front_used_reg) > SUM_W'(marker_reg)) begin
                    front_used_next = USED_W'(marker_reg);
                end
            end
            default: begin
                if (SUM_W'(back_used_reg) > SUM_W'(marker_reg)) begin
                    back_used_next = USED_W'(marker_reg);
                end
            end
        endcase
    end

    // Stack state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_used_reg <= '0;
            back_used_reg  <= '0;
        end else if (advance) begin
            front_used_reg <= front_used_next;
            back_used_reg  <= back_used_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            ok_reg   <= ok_next;
            addr_reg <= addr_next;
            mk_reg   <= mk_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A refused allocation carries a zero address and a zero marker.
    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !ok_reg) |-> (addr_reg == '0 && mk_reg == '0))
        else $error("refused result with nonzero address or marker");

    // A front reset never raises the front used count.
    a_reset_front_lowers: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && req_reg == REQ_RESET_FRONT)
            |=> (front_used_reg <= $past(front_used_reg)))
        else $error("front reset raised the used count");

    // A back reset never raises the back used count.
    a_reset_back_lowers: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && req_reg == REQ_RESET_BACK)
            |=> (back_used_reg <= $past(back_used_reg)))
        else $error("back reset raised the used count");

    // Without a compute step the stack state holds.
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> ($stable(front_used_reg) && $stable(back_used_reg)))
        else $error("stack state changed without a request");

    // Every compute step leaves a result waiting in the result register.
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("compute step did not load a result");
`endif

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended stack allocator testbench
// Drives request items into the allocator under several base/capacity
// settings, predicts every result from a private copy of both used counts and
// the registers, and compares each result item field by field, in order.
// Both stream sides stall at random, with one phase of back-to-back traffic.
// ----------------------------------------------------------------------------
module tb_top;
    import dea_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 6;
    localparam logic [20:0] FIELD21_MAX = 21'h1F_FFFF;

    // One predicted or observed result item.
    typedef struct packed {
        logic        ok;
        logic [31:0] address;
        logic [20:0] marker_out;
    } alloc_result_t;

    // Keeps the predicted allocator state and the results still owed by it.
    class alloc_scoreboard;
        logic [31:0]   base_addr = 32'd0;
        logic [20:0]   cap = CAPACITY_RESET;
        logic [20:0]   front_used = 21'd0;
        logic [20:0]   back_used = 21'd0;
        alloc_result_t pending[$];
        int            errors = 0;

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
            if (idx == CFG_BASE_ADDRESS) begin
                base_addr = value;
            end else begin
                cap = value[20:0];
            end
        endfunction

        // Applies one accepted request to the state and queues its result.
        function void note_request(logic [1:0] req, logic [20:0] size,
                                   logic [3:0] align, logic [20:0] marker, logic slot);
            alloc_result_t res;
            logic [31:0]   amask;
            logic [31:0]   cur;
            logic [31:0]   pad;
            logic [31:0]   below;
            logic [63:0]   grown;
            logic [63:0]   span;
            res = '0;
            amask = (32'd1 << align) - 32'd1;
            case (req)
                REQ_ALLOC_FRONT: begin
                    cur = base_addr + {11'd0, front_used};
                    pad = (32'd0 - cur) & amask;
                    span = 64'(front_used) + 64'(pad) + 64'(size) + 64'(back_used);
                    if (span <= 64'(cap) && slot) begin
                        res.ok = 1'b1;
                        res.address = cur + pad;
                        res.marker_out = front_used;
                        front_used = front_used + size + pad[20:0];
                    end
                end
                REQ_ALLOC_BACK: begin
                    grown = 64'(back_used) + 64'(size);
                    span = 64'(base_addr) + 64'(cap) - grown;
                    below = span[31:0];
                    pad = below & amask;
                    grown = grown + 64'(pad);
                    if (grown + 64'(front_used) <= 64'(cap) && slot) begin
                        res.ok = 1'b1;
                        res.address = below - pad;
                        res.marker_out = back_used;
                        back_used = grown[20:0];
                    end
                end
                REQ_RESET_FRONT: begin
                    if (front_used > marker) front_used = marker;
                    res.ok = 1'b1;
                end
                default: begin
                    if (back_used > marker) back_used = marker;
                    res.ok = 1'b1;
                end
            endcase
            pending.push_back(res);
        endfunction

        // Compares one result item with the oldest prediction.
        function void check_result(logic [M_TDATA_W-1:0] tdata);
            alloc_result_t exp_res;
            alloc_result_t got;
            got.ok = tdata[0];
            got.address = tdata[32:1];
            got.marker_out = tdata[53:33];
            if (pending.size() == 0) begin
                $display("%0t: result item with none expected, actual %h", $time, tdata);
                errors++;
            end else begin
                exp_res = pending.pop_front();
                if (got.ok !== exp_res.ok) begin
                    $display("%0t: ok mismatch, expected %0d, actual %0d",
                             $time, exp_res.ok, got.ok);
                    errors++;
                end
                if (got.address !== exp_res.address) begin
                    $display("%0t: address mismatch, expected %h, actual %h",
                             $time, exp_res.address, got.address);
                    errors++;
                end
                if (got.marker_out !== exp_res.marker_out) begin
                    $display("%0t: marker_out mismatch, expected %0d, actual %0d",
                             $time, exp_res.marker_out, got.marker_out);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [REQ_W-1:0]      s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    // When set, neither side inserts idle cycles.
    bit                    steady = 1'b0;
    int                    cycle_count = 0;

    alloc_scoreboard sb = new();

    double_ended_stack_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Result side: random back-pressure outside the steady stretch.
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 19);
    end

    // Every accepted result item is checked against the prediction queue.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL double_ended_stack_allocator");
            $finish;
        end
    end

    // One register write, after which the write enable is dropped again.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.write_register(idx, value);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Presents one request item and holds it until it is accepted.
    task automatic send_request(logic [1:0] req, logic [20:0] size, logic [3:0] align,
                                logic [20:0] marker, logic slot);
        while (!steady && $urandom_range(0, 99) < 19) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {1'b0, slot, marker, align, size};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(req, size, align, marker, slot);
    endtask

    // Mostly small, well-formed allocations and roll-backs to plausible
    // markers, with some oversized requests, busy slots and wild markers.
    task automatic random_request();
        int          pick;
        logic [1:0]  req;
        logic [20:0] size;
        logic [3:0]  align;
        logic [20:0] marker;
        logic [20:0] used;
        logic        slot;
        pick = $urandom_range(0, 99);
        if (pick < 35) req = REQ_ALLOC_FRONT;
        else if (pick < 70) req = REQ_ALLOC_BACK;
        else if (pick < 85) req = REQ_RESET_FRONT;
        else req = REQ_RESET_BACK;

        pick = $urandom_range(0, 99);
        if (pick < 65) size = 21'($urandom_range(0, 64));
        else if (pick < 90) size = 21'($urandom_range(0, 32'(sb.cap >> 3)));
        else size = 21'($urandom_range(0, 32'(FIELD21_MAX)));

        align = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(0, 6));
        slot = ($urandom_range(0, 9) != 0);

        used = (req == REQ_RESET_FRONT) ? sb.front_used : sb.back_used;
        pick = $urandom_range(0, 99);
        if (pick < 60) marker = 21'($urandom_range(0, 32'(used)));
        else if (pick < 80) marker = 21'd0;
        else marker = 21'($urandom_range(0, 32'(FIELD21_MAX)));

        send_request(req, size, align, marker, slot);
    endtask

    // Lets every owed result arrive, then idles the request side.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) random_request();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items at the reset settings: base 0, full capacity.
        send_request(REQ_ALLOC_FRONT, 21'd0, 4'd0, 21'd0, 1'b1);
        send_request(REQ_ALLOC_FRONT, 21'd1, 4'd0, 21'd0, 1'b1);
        send_request(REQ_ALLOC_FRONT, 21'd16, 4'd4, 21'd0, 1'b1);
        send_request(REQ_ALLOC_FRONT, 21'd8, 4'd15, 21'd0, 1'b1);
        send_request(REQ_ALLOC_FRONT, 21'd8, 4'd0, 21'd0, 1'b0);
        send_request(REQ_ALLOC_FRONT, FIELD21_MAX, 4'd0, FIELD21_MAX, 1'b1);
        send_request(REQ_ALLOC_BACK, 21'd100, 4'd0, 21'd0, 1'b1);
        send_request(REQ_ALLOC_BACK, 21'd100, 4'd12, 21'd0, 1'b1);
        send_request(REQ_ALLOC_BACK, 21'd0, 4'd15, 21'd0, 1'b1);
        send_request(REQ_ALLOC_BACK, 21'd4, 4'd2, 21'd0, 1'b0);
        send_request(REQ_ALLOC_BACK, FIELD21_MAX, 4'd0, 21'd0, 1'b1);
        // Roll-backs that must not raise a used count.
        send_request(REQ_RESET_FRONT, 21'd0, 4'd0, FIELD21_MAX, 1'b1);
        send_request(REQ_RESET_FRONT, 21'd0, 4'd0, sb.front_used, 1'b0);
        send_request(REQ_RESET_FRONT, FIELD21_MAX, 4'd15, 21'd0, 1'b1);
        send_request(REQ_RESET_BACK, 21'd0, 4'd0, 21'd50, 1'b1);
        send_request(REQ_RESET_BACK, 21'd0, 4'd0, 21'd0, 1'b1);
        // Exact fill of the region, then only zero-sized requests fit.
        send_request(REQ_ALLOC_FRONT, 21'd1048576, 4'd0, 21'd0, 1'b1);
        send_request(REQ_ALLOC_BACK, 21'd0, 4'd0, 21'd0, 1'b1);
        send_request(REQ_ALLOC_BACK, 21'd1, 4'd0, 21'd0, 1'b1);
        send_request(REQ_ALLOC_FRONT, 21'd0, 4'd1, 21'd0, 1'b1);
        send_request(REQ_RESET_FRONT, 21'd0, 4'd0, 21'd0, 1'b1);
        send_request(REQ_RESET_BACK, 21'd0, 4'd0, 21'd0, 1'b1);
        run_random(280);
        drain();

        // Top of the address space with the largest capacity: addresses wrap.
        write_register(CFG_BASE_ADDRESS, 32'hFFFF_FFFF);
        write_register(CFG_CAPACITY, 32'(FIELD21_MAX));
        run_random(300);
        drain();

        // Small region, overlap is frequent; no idling on either side.
        write_register(CFG_BASE_ADDRESS, $urandom());
        write_register(CFG_CAPACITY, 32'd4096);
        steady = 1'b1;
        run_random(350);
        drain();
        steady = 1'b0;

        // Empty region: only zero-sized, unpadded allocations and roll-backs can succeed.
        write_register(CFG_BASE_ADDRESS, 32'h1234_5678);
        write_register(CFG_CAPACITY, 32'd0);
        run_random(100);
        drain();

        // Region that runs across the wrap point.
        write_register(CFG_BASE_ADDRESS, 32'hFFFF_F000);
        write_register(CFG_CAPACITY, 32'(CAPACITY_RESET));
        run_random(300);
        drain();

        // Random settings; unused upper bits of the capacity write are noise.
        write_register(CFG_BASE_ADDRESS, $urandom());
        write_register(CFG_CAPACITY, $urandom());
        run_random(300);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS double_ended_stack_allocator");
        end else begin
            $display("FAIL double_ended_stack_allocator");
        end
        $finish;
    end

endmodule
